@@ sv/brb_pkg.sv @@
// shared types and constants for the byte ring buffer with dma head
// no dependencies
package brb_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_BURST_DEF   = 64;
    localparam int RING_MAX        = 256;
    localparam int IDX_W           = 8;
    localparam int LVL_W           = 9;
    localparam int CNT_W           = 7;
    localparam int OP_W            = 3;
    localparam int BYTE_W          = 8;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 24;
    localparam int OQ_DEPTH        = 3;

    localparam logic [LVL_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_DROP   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_SWRITE = 3'd5,
        OP_HEAD   = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BURST,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_cmd;

    typedef struct packed {
        logic             ok;
        logic             last;
        logic [LVL_W-1:0] fill;
        logic             sel;
    } t_result;

    typedef struct packed {
        logic              ok;
        logic              last;
        logic [BYTE_W-1:0] data;
        logic [LVL_W-1:0]  fill;
    } t_out;

endpackage

@@ sv/byte_ring_buffer_with_dma_head_unit.sv @@
// top level of the byte ring buffer with dma head
// depends on brb_pkg, brb_store, brb_ctrl, brb_oq
//
// Usage
//   s_axis carries one operation per word: push, pop n, peek n, drop n,
//   clear, raw store write (dma) and head update. m_axis returns result
//   words: ok in tuser, last in tlast, read byte and fill level in tdata.
//   i_cfg_we/i_cfg_wdata write the ring size; this also zeroes the
//   pointers and the level. Write it only while the block is idle.
//   Each result is registered in brb_ctrl with its store read, then written
//   into the output queue before it appears. Throughput: one single-result
//   operation per cycle while the output queue has room; pop n and peek n
//   give one byte per cycle from the store read port while the queue has room;
//   clear sweeps zeros through the store, one entry per cycle on the single write port.
//   Reset: pointers and level zero, ring size 256; store contents are
//   undefined until written.
//   Stall: results queue in a three-word output queue; when it fills,
//   s_axis_tready falls and any burst in progress pauses.
module byte_ring_buffer_with_dma_head_unit #(
    parameter int STORE_DEPTH = brb_pkg::STORE_DEPTH_DEF,
    parameter int MAX_BURST   = brb_pkg::MAX_BURST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [brb_pkg::LVL_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op[2:0], data_in[10:3], count[17:11], index[25:18], zero pad
    input  logic [brb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_out[7:0], fill_level[16:8], zero pad
    output logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // ok[0]
    output logic                            m_axis_tuser
);
    import brb_pkg::*;

    localparam int MEM_DEPTH = (STORE_DEPTH < RING_MAX) ? STORE_DEPTH : RING_MAX;

    t_mem_cmd          mem_cmd;
    logic [BYTE_W-1:0] rdata;
    logic              room;
    logic              pv;
    t_result           pres;
    t_out              word;

    brb_ctrl #(
        .RING_LIMIT (MEM_DEPTH),
        .MAX_BURST  (MAX_BURST)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tdata[2:0]),
        .i_din       (s_axis_tdata[10:3]),
        .i_cnt       (s_axis_tdata[17:11]),
        .i_idx       (s_axis_tdata[25:18]),
        .i_room      (room),
        .o_mem       (mem_cmd),
        .o_pv        (pv),
        .o_pres      (pres)
    );

    brb_store #(
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (rdata)
    );

    brb_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pv),
        .i_res   (pres),
        .i_rdata (rdata),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (word)
    );

    assign m_axis_tdata = {7'b0000000, word.fill, word.data};
    assign m_axis_tlast = word.last;
    assign m_axis_tuser = word.ok;

endmodule

@@ sv/brb_store.sv @@
// byte store: synchronous ram, one write and one registered read port
// depends on brb_pkg
module brb_store #(
    parameter int DEPTH = brb_pkg::RING_MAX
) (
    input  logic                   i_clk,
    input  brb_pkg::t_mem_cmd      i_cmd,
    output logic [brb_pkg::BYTE_W-1:0] o_rdata
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr[AW-1:0]] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            o_rdata <= mem[i_cmd.raddr[AW-1:0]];
        end
    end

endmodule

@@ sv/brb_ctrl.sv @@
// ring control: pointers, level, op decode, burst and clear sequencer
// depends on brb_pkg; drives brb_store and feeds brb_oq
module brb_ctrl #(
    parameter int RING_LIMIT = brb_pkg::RING_MAX,
    parameter int MAX_BURST  = brb_pkg::MAX_BURST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [brb_pkg::LVL_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [brb_pkg::OP_W-1:0]   i_op,
    input  logic [brb_pkg::BYTE_W-1:0] i_din,
    input  logic [brb_pkg::CNT_W-1:0]  i_cnt,
    input  logic [brb_pkg::IDX_W-1:0]  i_idx,
    input  logic                       i_room,
    output brb_pkg::t_mem_cmd          o_mem,
    output logic                       o_pv,
    output brb_pkg::t_result           o_pres
);
    import brb_pkg::*;

    localparam logic [LVL_W-1:0] SIZE_MAX = LVL_W'(RING_LIMIT);
    localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(MAX_BURST);

    t_state           r_state, n_state;
    logic [LVL_W-1:0] r_size, n_size;
    logic [IDX_W-1:0] r_wp, n_wp;
    logic [IDX_W-1:0] r_rp, n_rp;
    logic [LVL_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_left, n_left;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0] r_clr_end, n_clr_end;
    logic             r_pv;
    t_result          r_pres;

    logic             acc;
    logic             issue;
    t_result          res;
    t_op              op;
    logic [LVL_W-1:0] size;
    logic [LVL_W-1:0] cnt9;
    logic             push_full;
    logic             burst_bad;
    logic             idx_bad;
    logic [LVL_W-1:0] pos_sum;
    logic [IDX_W-1:0] burst_rp;
    logic [IDX_W-1:0] wp_inc;
    logic [IDX_W-1:0] rp_inc;
    logic [IDX_W-1:0] pos_inc;
    logic [LVL_W:0]   moved_w;
    logic [LVL_W-1:0] moved;
    logic             over;

    // decode
    always_comb begin
        if (r_size < 9'd2) begin
            size = 9'd2;
        end else if (r_size > SIZE_MAX) begin
            size = SIZE_MAX;
        end else begin
            size = r_size;
        end
        op        = t_op'(i_op);
        cnt9      = {2'b00, i_cnt};
        push_full = ({1'b0, r_count} + 10'd1) >= {1'b0, size};
        burst_bad = (i_cnt > BURST_MAX) || (cnt9 > r_count);
        idx_bad   = {1'b0, i_idx} >= size;
        pos_sum   = {1'b0, r_rp} + cnt9;
        burst_rp  = (pos_sum >= size) ? IDX_W'(pos_sum - size) : IDX_W'(pos_sum);
        wp_inc    = (({1'b0, r_wp} + 9'd1) == size) ? '0 : r_wp + 8'd1;
        rp_inc    = (({1'b0, r_rp} + 9'd1) == size) ? '0 : r_rp + 8'd1;
        pos_inc   = (({1'b0, r_pos} + 9'd1) == size) ? '0 : r_pos + 8'd1;
        if (i_idx >= r_wp) begin
            moved_w = {2'b00, i_idx} - {2'b00, r_wp};
        end else begin
            moved_w = {2'b00, i_idx} + {1'b0, size} - {2'b00, r_wp};
        end
        moved = moved_w[LVL_W-1:0];
        over  = ({1'b0, moved} + {1'b0, r_count}) > {1'b0, size};
    end

    assign o_ready = (r_state == ST_IDLE) && i_room;
    assign acc     = i_valid && o_ready;

    // next state
    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_count   = r_count;
        n_pos     = r_pos;
        n_left    = r_left;
        n_clr     = r_clr;
        n_clr_end = r_clr_end;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (op)
                        OP_PUSH: begin
                            if (!push_full) begin
                                n_wp    = wp_inc;
                                n_count = r_count + 9'd1;
                            end
                        end
                        OP_POP, OP_PEEK, OP_DROP: begin
                            if (!burst_bad) begin
                                if (op != OP_PEEK) begin
                                    n_rp    = burst_rp;
                                    n_count = r_count - cnt9;
                                end
                                if (op != OP_DROP && i_cnt > 7'd1) begin
                                    n_state = ST_BURST;
                                    n_pos   = rp_inc;
                                    n_left  = i_cnt - 7'd1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_wp      = '0;
                            n_rp      = '0;
                            n_count   = '0;
                            n_state   = ST_CLEAR;
                            n_clr     = 8'd1;
                            n_clr_end = IDX_W'(size - 9'd1);
                        end
                        OP_HEAD: begin
                            if (!idx_bad) begin
                                if (over) begin
                                    n_rp    = i_idx;
                                    n_count = size;
                                end else begin
                                    n_count = r_count + moved;
                                end
                                n_wp = i_idx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BURST: begin
                if (i_room) begin
                    n_pos  = pos_inc;
                    n_left = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                n_clr = r_clr + 8'd1;
                if (r_clr == r_clr_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_size  = i_cfg_wdata;
            n_wp    = '0;
            n_rp    = '0;
            n_count = '0;
        end
    end

    // outputs
    always_comb begin
        o_mem    = '0;
        issue    = 1'b0;
        res      = '0;
        res.last = 1'b1;
        res.fill = n_count;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    issue = 1'b1;
                    case (op)
                        OP_PUSH: begin
                            res.ok = !push_full;
                            if (!push_full) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_wp;
                                o_mem.wdata = i_din;
                            end
                        end
                        OP_POP, OP_PEEK, OP_DROP: begin
                            res.ok = !burst_bad;
                            if (!burst_bad && op != OP_DROP && i_cnt != 7'd0) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_rp;
                                res.sel     = 1'b1;
                                res.last    = (i_cnt == 7'd1);
                            end
                        end
                        OP_CLEAR: begin
                            res.ok   = 1'b1;
                            o_mem.we = 1'b1;
                        end
                        OP_SWRITE: begin
                            res.ok = !idx_bad;
                            if (!idx_bad) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = i_idx;
                                o_mem.wdata = i_din;
                            end
                        end
                        OP_HEAD: begin
                            res.ok = !idx_bad;
                        end
                        default: begin
                            res.ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_BURST: begin
                if (i_room) begin
                    issue       = 1'b1;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_pos;
                    res.ok      = 1'b1;
                    res.sel     = 1'b1;
                    res.last    = (r_left == 7'd1);
                    res.fill    = r_count;
                end
            end
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_size  <= SIZE_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_pv    <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_clr     <= n_clr;
        r_clr_end <= n_clr_end;
        r_pres    <= res;
    end

    assign o_pv   = r_pv;
    assign o_pres = r_pres;

endmodule

@@ sv/brb_oq.sv @@
// three-word output queue joining result tags with store read data
// depends on brb_pkg
module brb_oq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  brb_pkg::t_result           i_res,
    input  logic [brb_pkg::BYTE_W-1:0] i_rdata,
    output logic                       o_room,
    output logic                       o_valid,
    input  logic                       i_ready,
    output brb_pkg::t_out              o_word
);
    import brb_pkg::*;

    localparam logic [1:0] LAST_SLOT = 2'(OQ_DEPTH - 1);
    localparam logic [2:0] DEPTH3    = 3'(OQ_DEPTH);

    t_out       q [OQ_DEPTH];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    t_out       word_in;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_room  = ({1'b0, r_cnt} + {2'b00, i_valid}) < DEPTH3;
    assign o_word  = q[r_rd];

    always_comb begin
        word_in.ok   = i_res.ok;
        word_in.last = i_res.last;
        word_in.data = i_res.sel ? i_rdata : '0;
        word_in.fill = i_res.fill;
        n_wr  = i_valid ? ((r_wr == LAST_SLOT) ? 2'd0 : r_wr + 2'd1) : r_wr;
        n_rd  = pop ? ((r_rd == LAST_SLOT) ? 2'd0 : r_rd + 2'd1) : r_rd;
        n_cnt = r_cnt + {1'b0, i_valid} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            q[r_wr] <= word_in;
        end
    end

endmodule

@@ sv/brb_checker.sv @@
// port-level checks on the result stream of the byte ring buffer
// depends on brb_pkg; bound to byte_ring_buffer_with_dma_head_unit
module brb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import brb_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a refused op gives one word, no data
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("refused op with data or without last");

    // only successful bursts give non-last words
    a_burst_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-last word of a refused op");

    // fill constant inside a burst and within the ring bound on its later words
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata[16:8] == $past(m_axis_tdata[16:8])
            && m_axis_tdata[16:8] <= 9'(RING_MAX)))
        else $error("fill level moved within a burst");

endmodule

bind byte_ring_buffer_with_dma_head_unit brb_checker u_brb_checker (.*);
